// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files of the symbol hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/shli_pkg.sv -----
// Package for the symbol hash block: item types and status codes.
`default_nettype none

package shli_pkg;

	localparam int MAX_NAME_BYTES = 16;
	localparam int NAME_LEN_W     = 5;
	localparam int ENTRY_NUM_W    = 9;

	localparam logic [1:0] STATUS_FOUND    = 2'd0;
	localparam logic [1:0] STATUS_CREATED  = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [63:0]           name_low_bytes;
		logic [63:0]           name_high_bytes;
		logic [NAME_LEN_W-1:0] name_length;
	} name_item_t;

	typedef struct packed {
		logic [ENTRY_NUM_W-1:0] entry_number;
		logic [1:0]             status;
	} result_item_t;

endpackage

`default_nettype wire

// ----- rtl/symbol_hash_lookup_insert_core.sv -----
// Symbol lookup-or-insert: open-addressed hash table with downward linear probing.
//
// Usage: a name item (up to 16 bytes plus a length) enters on name_valid/name_stall,
// one result item (entry number and status) leaves on result_valid/result_stall.
// An item is taken when valid is high and stall is low. One item is worked on at a
// time; name_stall is high until the item's result sits in the output register.
// Steps: the item is accepted and hashed byte-serially; each slot probe then reads the slot
// memory (registered) and checks the slot; an occupied slot also reads the name memory
// (registered) and compares the name; the result then goes into the output register.
// Reset: the slot memory is swept empty, one slot a cycle; no
// item is taken until the sweep ends. The entry counter restarts at zero.
// A stalled result holds in the output register; the next item may be accepted and
// worked on meanwhile, and waits for the register to free before it is shown.
// SLOT_COUNT must be a power of two.
`default_nettype none

module symbol_hash_lookup_insert_core #(
	parameter int SLOT_COUNT  = 1024,
	parameter int ENTRY_COUNT = 512
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   name_valid,
	output logic                        name_stall,
	input  wire shli_pkg::name_item_t   name_item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output shli_pkg::result_item_t      result_item
);

	`include "assert_macros.svh"

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int ENT_W  = $clog2(ENTRY_COUNT);
	localparam int LEN_W  = shli_pkg::NAME_LEN_W;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [63:0]      hi;
		logic [63:0]      lo;
	} name_rec_t;

	typedef struct packed {
		logic             valid;
		logic [ENT_W-1:0] entry;
	} slot_rec_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_SLOT_RD, ST_SLOT_CHK, ST_NAME_RD, ST_NAME_CMP, ST_DONE
	} state_t;

	state_t                   state_q;
	logic [SLOT_W-1:0]        clr_q;
	logic [SLOT_W-1:0]        probe_slot_q;
	logic [SLOT_W:0]          probes_q;
	logic [ENT_W:0]           next_free_q;
	logic [ENT_W-1:0]         entry_q;
	name_rec_t                name_q;
	shli_pkg::result_item_t   res_q;
	shli_pkg::result_item_t   result_q;
	logic                     result_valid_q;

	slot_rec_t                slot_mem [SLOT_COUNT];
	name_rec_t                name_mem [ENTRY_COUNT];
	slot_rec_t                slot_rd_q;
	name_rec_t                name_rd_q;

	name_rec_t                name_in;
	logic [LEN_W-1:0]         len_sat;
	logic                     hash_start;
	logic                     hash_done;
	logic [SLOT_W-1:0]        hash_slot;
	logic                     store_full;
	logic                     slot_we;
	logic [SLOT_W-1:0]        slot_wa;
	slot_rec_t                slot_wd;
	logic                     name_we;
	logic                     name_match;

	// Saturate the length and zero the bytes beyond it.
	always_comb begin
		len_sat = (name_item.name_length > LEN_W'(shli_pkg::MAX_NAME_BYTES)) ?
			LEN_W'(shli_pkg::MAX_NAME_BYTES) : name_item.name_length;
		name_in.len = len_sat;
		for (int k = 0; k < 8; k++) begin
			name_in.lo[k*8 +: 8] = (LEN_W'(k) < len_sat) ?
				name_item.name_low_bytes[k*8 +: 8] : 8'd0;
			name_in.hi[k*8 +: 8] = (LEN_W'(k + 8) < len_sat) ?
				name_item.name_high_bytes[k*8 +: 8] : 8'd0;
		end
	end

	assign name_stall   = (state_q != ST_IDLE);
	assign hash_start   = (state_q == ST_IDLE) && name_valid;
	assign store_full   = (next_free_q == (ENT_W+1)'(ENTRY_COUNT));
	assign name_match   = (name_rd_q == name_q);
	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	// The length is latched at the accept edge; the bytes are read from name_q after it.
	shli_hash #(
		.SLOT_BITS(SLOT_W)
	) u_hash (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (hash_start),
		.name_low_bytes (name_q.lo),
		.name_high_bytes(name_q.hi),
		.name_length    (name_in.len),
		.done           (hash_done),
		.slot           (hash_slot)
	);

	// Single write port: reset sweep or insertion of a new entry.
	always_comb begin
		slot_we = 1'b0;
		slot_wa = probe_slot_q;
		slot_wd = '{valid: 1'b1, entry: next_free_q[ENT_W-1:0]};
		name_we = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				slot_we = 1'b1;
				slot_wa = clr_q;
				slot_wd = '0;
			end
			ST_SLOT_CHK: begin
				if (!slot_rd_q.valid && !store_full) begin
					slot_we = 1'b1;
					name_we = 1'b1;
				end
			end
			default: begin
				slot_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		slot_rd_q <= slot_mem[probe_slot_q];
	end

	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[next_free_q[ENT_W-1:0]] <= name_q;
		end
		name_rd_q <= name_mem[entry_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			probe_slot_q   <= '0;
			probes_q       <= '0;
			next_free_q    <= '0;
			entry_q        <= '0;
			name_q         <= '0;
			res_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (name_valid) begin
						name_q  <= name_in;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						probe_slot_q <= hash_slot;
						probes_q     <= '0;
						state_q      <= ST_SLOT_RD;
					end
				end
				ST_SLOT_RD: begin
					if (probes_q == (SLOT_W+1)'(SLOT_COUNT)) begin
						res_q   <= '{entry_number: '0, status: shli_pkg::STATUS_OVERFLOW};
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SLOT_CHK;
					end
				end
				ST_SLOT_CHK: begin
					if (!slot_rd_q.valid) begin
						if (store_full) begin
							res_q <= '{entry_number: '0, status: shli_pkg::STATUS_OVERFLOW};
						end else begin
							res_q <= '{entry_number: shli_pkg::ENTRY_NUM_W'(next_free_q),
								status: shli_pkg::STATUS_CREATED};
							next_free_q <= next_free_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						entry_q <= slot_rd_q.entry;
						state_q <= ST_NAME_RD;
					end
				end
				ST_NAME_RD: begin
					state_q <= ST_NAME_CMP;
				end
				ST_NAME_CMP: begin
					if (name_match) begin
						res_q   <= '{entry_number: shli_pkg::ENTRY_NUM_W'(entry_q),
							status: shli_pkg::STATUS_FOUND};
						state_q <= ST_DONE;
					end else begin
						// power-of-two table: decrement wraps from slot 0 to the top
						probe_slot_q <= probe_slot_q - 1'b1;
						probes_q     <= probes_q + 1'b1;
						state_q      <= ST_SLOT_RD;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q       <= res_q;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_free_bound, next_free_q <= (ENT_W+1)'(ENTRY_COUNT), "entry counter past store size")
	`ASSERT_ALWAYS(a_probe_bound, probes_q <= (SLOT_W+1)'(SLOT_COUNT), "probe count past slot count")
	`ASSERT_IMPLY(a_free_step, !$stable(next_free_q), next_free_q == $past(next_free_q) + 1'b1, "entry counter jumped")
	`ASSERT_IMPLY(a_result_src, $rose(result_valid_q), $past(state_q) == ST_DONE, "result shown outside done step")
	`ASSERT_IMPLY(a_slot_write, slot_we && state_q != ST_CLEAR, !store_full, "insert into full store")

endmodule

`default_nettype wire

// ----- rtl/shli_hash.sv -----
// Iterative name hasher: one shift-add step per byte, then fold and mask.
`default_nettype none

module shli_hash #(
	parameter int SLOT_BITS = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [63:0]                         name_low_bytes,
	input  wire logic [63:0]                         name_high_bytes,
	input  wire logic [shli_pkg::NAME_LEN_W-1:0]     name_length,
	output logic                                     done,
	output logic [SLOT_BITS-1:0]                     slot
);

	localparam logic [31:0] HASH_SEED = 32'd12345;

	logic                              busy_q;
	logic [3:0]                        idx_q;
	logic [shli_pkg::NAME_LEN_W-1:0]   left_q;
	logic [31:0]                       h_q;
	logic [127:0]                      bytes;
	logic [7:0]                        cur_byte;
	logic [31:0]                       fold;

	assign bytes    = {name_high_bytes, name_low_bytes};
	assign cur_byte = bytes[{idx_q, 3'b000} +: 8];
	assign fold     = h_q ^ {16'd0, h_q[31:16]};
	assign slot     = fold[SLOT_BITS-1:0];
	assign done     = busy_q && (left_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			left_q <= '0;
			h_q    <= HASH_SEED;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			left_q <= name_length;
			h_q    <= HASH_SEED;
		end else if (busy_q) begin
			if (left_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				h_q    <= {h_q[30:0], 1'b0} + {24'd0, cur_byte};
				idx_q  <= idx_q + 4'd1;
				left_q <= left_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
